FILE: hw/rtl/cpm_pkg.sv
`timescale 1ns / 1ps

package cpm_pkg;

  localparam int NODES      = 64;
  localparam int NODE_W     = 6;
  localparam int TIME_W     = 10;
  localparam int TASK_LIMIT = 62;

  // input actions
  localparam logic [1:0] ACT_DUR   = 2'd0;
  localparam logic [1:0] ACT_EDGE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_RUN   = 2'd3;

  // configuration register index
  localparam logic REG_TASK_COUNT = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT_ROW,
    ST_INIT_CAP,
    ST_INIT_ISSUE,
    ST_INIT_USE,
    ST_INIT_WR,
    ST_FWD_SEED,
    ST_FWD_POP,
    ST_FWD_ROW,
    ST_FWD_FIN,
    ST_FWD_SCAN,
    ST_FWD_UPD,
    ST_FWD_END,
    ST_FWD_LEN,
    ST_BWD_SEED,
    ST_BWD_POP,
    ST_BWD_LS,
    ST_BWD_CAP,
    ST_BWD_ISSUE,
    ST_BWD_UPD,
    ST_OUT_ISSUE,
    ST_OUT_EMIT
  } state_t;

  // read address source
  typedef enum logic [1:0] {
    A_I,
    A_J,
    A_Q,
    A_E
  } asel_t;

  typedef struct packed {
    asel_t asel;
    logic  load;
    logic  begin_run;
    logic  init_cap;
    logic  init_acc;
    logic  init_wr;
    logic  seed_fwd;
    logic  pop;
    logic  take_node;
    logic  fwd_fin;
    logic  adv_j;
    logic  fwd_upd;
    logic  end_cap;
    logic  bwd_seed;
    logic  bwd_cap;
    logic  bwd_upd;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic out_last;
    logic q_empty;
    logic bit_set;
    logic end_neg;
  } status_t;

endpackage

FILE: hw/rtl/cpm_ctrl.sv
`timescale 1ns / 1ps

module cpm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          action,
  input  cpm_pkg::status_t    stat,
  output logic                busy,
  output cpm_pkg::cmd_t       cmd
);

  cpm_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != cpm_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.asel   = cpm_pkg::A_I;
    case (state)
      cpm_pkg::ST_IDLE: begin
        if (start) begin
          if (action == cpm_pkg::ACT_RUN) begin
            cmd.begin_run = 1'b1;
            state_next    = cpm_pkg::ST_INIT_ROW;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      cpm_pkg::ST_INIT_ROW: begin
        cmd.asel   = cpm_pkg::A_I;
        state_next = cpm_pkg::ST_INIT_CAP;
      end
      cpm_pkg::ST_INIT_CAP: begin
        cmd.init_cap = 1'b1;
        state_next   = cpm_pkg::ST_INIT_ISSUE;
      end
      cpm_pkg::ST_INIT_ISSUE: begin
        cmd.asel   = cpm_pkg::A_J;
        state_next = cpm_pkg::ST_INIT_USE;
      end
      cpm_pkg::ST_INIT_USE: begin
        cmd.init_acc = 1'b1;
        state_next   = stat.j_last ? cpm_pkg::ST_INIT_WR : cpm_pkg::ST_INIT_ISSUE;
      end
      cpm_pkg::ST_INIT_WR: begin
        cmd.init_wr = 1'b1;
        state_next  = stat.i_last ? cpm_pkg::ST_FWD_SEED : cpm_pkg::ST_INIT_ROW;
      end
      cpm_pkg::ST_FWD_SEED: begin
        cmd.seed_fwd = 1'b1;
        state_next   = cpm_pkg::ST_FWD_POP;
      end
      cpm_pkg::ST_FWD_POP: begin
        if (stat.q_empty) begin
          state_next = cpm_pkg::ST_FWD_END;
        end else begin
          cmd.pop    = 1'b1;
          state_next = cpm_pkg::ST_FWD_ROW;
        end
      end
      cpm_pkg::ST_FWD_ROW: begin
        cmd.asel      = cpm_pkg::A_Q;
        cmd.take_node = 1'b1;
        state_next    = cpm_pkg::ST_FWD_FIN;
      end
      cpm_pkg::ST_FWD_FIN: begin
        cmd.fwd_fin = 1'b1;
        state_next  = cpm_pkg::ST_FWD_SCAN;
      end
      cpm_pkg::ST_FWD_SCAN: begin
        cmd.asel = cpm_pkg::A_J;
        if (stat.bit_set) begin
          state_next = cpm_pkg::ST_FWD_UPD;
        end else begin
          cmd.adv_j = 1'b1;
          if (stat.j_last) begin
            state_next = cpm_pkg::ST_FWD_POP;
          end
        end
      end
      cpm_pkg::ST_FWD_UPD: begin
        cmd.fwd_upd = 1'b1;
        state_next  = stat.j_last ? cpm_pkg::ST_FWD_POP : cpm_pkg::ST_FWD_SCAN;
      end
      cpm_pkg::ST_FWD_END: begin
        cmd.asel   = cpm_pkg::A_E;
        state_next = cpm_pkg::ST_FWD_LEN;
      end
      cpm_pkg::ST_FWD_LEN: begin
        cmd.end_cap = 1'b1;
        state_next  = stat.end_neg ? cpm_pkg::ST_OUT_ISSUE : cpm_pkg::ST_BWD_SEED;
      end
      cpm_pkg::ST_BWD_SEED: begin
        cmd.bwd_seed = 1'b1;
        state_next   = cpm_pkg::ST_BWD_POP;
      end
      cpm_pkg::ST_BWD_POP: begin
        if (stat.q_empty) begin
          state_next = cpm_pkg::ST_OUT_ISSUE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = cpm_pkg::ST_BWD_LS;
        end
      end
      cpm_pkg::ST_BWD_LS: begin
        cmd.asel      = cpm_pkg::A_Q;
        cmd.take_node = 1'b1;
        state_next    = cpm_pkg::ST_BWD_CAP;
      end
      cpm_pkg::ST_BWD_CAP: begin
        cmd.bwd_cap = 1'b1;
        state_next  = cpm_pkg::ST_BWD_ISSUE;
      end
      cpm_pkg::ST_BWD_ISSUE: begin
        cmd.asel   = cpm_pkg::A_J;
        state_next = cpm_pkg::ST_BWD_UPD;
      end
      cpm_pkg::ST_BWD_UPD: begin
        cmd.bwd_upd = 1'b1;
        state_next  = stat.j_last ? cpm_pkg::ST_BWD_POP : cpm_pkg::ST_BWD_ISSUE;
      end
      cpm_pkg::ST_OUT_ISSUE: begin
        cmd.asel   = cpm_pkg::A_I;
        state_next = cpm_pkg::ST_OUT_EMIT;
      end
      cpm_pkg::ST_OUT_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = stat.out_last ? cpm_pkg::ST_IDLE : cpm_pkg::ST_OUT_ISSUE;
      end
      default: begin
        state_next = cpm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/cpm_datapath.sv
`timescale 1ns / 1ps

module cpm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  cpm_pkg::cmd_t                     cmd,
  output cpm_pkg::status_t                  stat,
  input  logic [cpm_pkg::NODE_W-1:0]        task_count,
  input  logic [1:0]                        action,
  input  logic [cpm_pkg::NODE_W-1:0]        node_a,
  input  logic [cpm_pkg::NODE_W-1:0]        node_b,
  input  logic [cpm_pkg::TIME_W-1:0]        task_time,
  output logic                              result_valid,
  output logic [cpm_pkg::NODE_W-1:0]        task_id,
  output logic signed [16:0]                earliest_start,
  output logic signed [16:0]                early_finish,
  output logic signed [16:0]                late_start,
  output logic [15:0]                       late_finish,
  output logic                              on_critical,
  output logic [15:0]                       project_length,
  output logic                              last_task
);

  localparam int NW = cpm_pkg::NODE_W;
  localparam int NN = cpm_pkg::NODES;

  // stores
  logic [NN-1:0]                 mat [NN];
  logic [cpm_pkg::TIME_W-1:0]    dur [NN];
  logic [6:0]                    pp_mem [NN];
  logic [6:0]                    ps_mem [NN];
  logic signed [16:0]            es_mem [NN];
  logic signed [16:0]            ef_mem [NN];
  logic signed [16:0]            ls_mem [NN];
  logic [15:0]                   lf_mem [NN];
  logic [NW-1:0]                 queue [NN];

  logic [NN-1:0] row_valid;
  logic [NN-1:0] dur_valid;

  // registered read data
  logic [NN-1:0]              mat_rd;
  logic                       row_ok;
  logic [cpm_pkg::TIME_W-1:0] d_q;
  logic                       d_ok;
  logic [6:0]                 pp_q;
  logic [6:0]                 ps_q;
  logic signed [16:0]         es_q;
  logic signed [16:0]         ef_q;
  logic signed [16:0]         ls_q;
  logic [15:0]                lf_q;
  logic [NW-1:0]              q_q;

  // walk registers
  logic [NW-1:0]      e;
  logic [NW-1:0]      i;
  logic [NW-1:0]      j;
  logic [NW-1:0]      cur;
  logic [6:0]         np;
  logic [6:0]         ns;
  logic [NN-1:0]      rowi;
  logic [NN-1:0]      row;
  logic [15:0]        fin;
  logic [15:0]        lsv;
  logic [NW-1:0]      head;
  logic [NW:0]        tail;
  logic signed [16:0] es_end;
  logic [15:0]        ef_end;
  logic [15:0]        plen;

  logic [NW-1:0]              addr;
  logic [NW-1:0]              n_eff;
  logic [NN-1:0]              mrow;
  logic [NN-1:0]              edge_row;
  logic [cpm_pkg::TIME_W-1:0] dnode;
  logic [6:0]                 pp_dec;
  logic [6:0]                 ps_dec;
  logic                       upd_es;
  logic [16:0]                fsum;
  logic signed [16:0]         fnew;
  logic                       bbit;
  logic                       upd_lf;
  logic [15:0]                dnode16;
  logic [15:0]                snew;
  logic                       push_f;
  logic                       push_b;
  logic                       ld_dur;
  logic                       ld_edge;
  logic                       ld_clear;

  // effective task count
  always_comb begin
    if (task_count == '0) begin
      n_eff = NW'(1);
    end else if (task_count > NW'(cpm_pkg::TASK_LIMIT)) begin
      n_eff = NW'(cpm_pkg::TASK_LIMIT);
    end else begin
      n_eff = task_count;
    end
  end

  // shared read address
  always_comb begin
    case (cmd.asel)
      cpm_pkg::A_I: addr = i;
      cpm_pkg::A_J: addr = j;
      cpm_pkg::A_Q: addr = q_q;
      cpm_pkg::A_E: addr = e;
      default:      addr = i;
    endcase
  end

  assign ld_dur   = cmd.load && (action == cpm_pkg::ACT_DUR);
  assign ld_edge  = cmd.load && (action == cpm_pkg::ACT_EDGE);
  assign ld_clear = cmd.load && (action == cpm_pkg::ACT_CLEAR);

  assign edge_row = {{(NN-1){1'b0}}, 1'b1} << node_b;
  assign mrow     = row_ok ? mat_rd : '0;

  // node duration, zero for start and end and for nodes with no duration loaded
  assign dnode   = ((j == '0) || (j >= e) || !d_ok) ? '0 : d_q;
  assign dnode16 = 16'(dnode);

  // forward relax
  assign pp_dec = (pp_q != '0) ? pp_q - 7'd1 : 7'd0;
  assign upd_es = es_q < $signed({1'b0, fin});
  assign fsum   = {1'b0, fin} + 17'(dnode);
  assign fnew   = fsum[16] ? 17'sh0FFFF : $signed(fsum);
  assign push_f = cmd.fwd_upd && (pp_dec == '0) && (j != '0) && (j != e) && !tail[NW];

  // backward relax
  assign bbit   = mrow[cur];
  assign ps_dec = (ps_q != '0) ? ps_q - 7'd1 : 7'd0;
  assign upd_lf = bbit && (lf_q > lsv);
  assign snew   = (lsv >= dnode16) ? lsv - dnode16 : 16'd0;
  assign push_b = cmd.bwd_upd && bbit && (ps_dec == '0) && (j != '0) && (j != e)
                  && !tail[NW];

  // status
  assign stat.j_last   = (j == e);
  assign stat.i_last   = (i == e);
  assign stat.out_last = (i == e - NW'(1));
  assign stat.q_empty  = ({1'b0, head} == tail);
  assign stat.bit_set  = row[j];
  assign stat.end_neg  = es_q[16];

  // memories
  always_ff @(posedge clk) begin
    mat_rd <= mat[addr];
    d_q    <= dur[addr];
    pp_q   <= pp_mem[addr];
    ps_q   <= ps_mem[addr];
    es_q   <= es_mem[addr];
    ef_q   <= ef_mem[addr];
    ls_q   <= ls_mem[addr];
    lf_q   <= lf_mem[addr];
    q_q    <= queue[head];

    if (ld_edge) begin
      if (row_valid[node_a]) begin
        mat[node_a][node_b] <= 1'b1;
      end else begin
        mat[node_a] <= edge_row;
      end
    end
    if (ld_dur) begin
      dur[node_a] <= task_time;
    end

    if (cmd.init_wr) begin
      pp_mem[i] <= np;
      ps_mem[i] <= ns;
      es_mem[i] <= (i == '0) ? 17'sd0 : -17'sd1;
      ef_mem[i] <= (i == '0) ? 17'sd0 : -17'sd1;
      ls_mem[i] <= -17'sd1;
      lf_mem[i] <= 16'hFFFF;
    end
    if (cmd.fwd_upd) begin
      pp_mem[j] <= pp_dec;
      if (upd_es) begin
        es_mem[j] <= $signed({1'b0, fin});
        ef_mem[j] <= fnew;
      end
    end
    if (cmd.bwd_seed) begin
      ls_mem[e] <= es_end;
      lf_mem[e] <= ef_end;
    end
    if (cmd.bwd_upd && bbit) begin
      ps_mem[j] <= ps_dec;
      if (upd_lf) begin
        lf_mem[j] <= lsv;
        ls_mem[j] <= $signed({1'b0, snew});
      end
    end

    if (cmd.seed_fwd) begin
      queue[0] <= '0;
    end else if (cmd.bwd_seed) begin
      queue[0] <= e;
    end else if (push_f || push_b) begin
      queue[tail[NW-1:0]] <= j;
    end
  end

  // valid bits, queue pointers and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid    <= '0;
      dur_valid    <= '0;
      result_valid <= 1'b0;
      row_ok       <= 1'b0;
      d_ok         <= 1'b0;
      head         <= '0;
      tail         <= '0;
    end else begin
      row_ok       <= row_valid[addr];
      d_ok         <= dur_valid[addr];
      result_valid <= cmd.emit;
      if (ld_clear) begin
        row_valid <= '0;
        dur_valid <= '0;
      end
      if (ld_edge) begin
        row_valid[node_a] <= 1'b1;
      end
      if (ld_dur) begin
        dur_valid[node_a] <= 1'b1;
      end
      if (cmd.seed_fwd || cmd.bwd_seed) begin
        head <= '0;
        tail <= (NW+1)'(1);
      end else begin
        if (cmd.pop) begin
          head <= head + NW'(1);
        end
        if (push_f || push_b) begin
          tail <= tail + (NW+1)'(1);
        end
      end
    end
  end

  // walk counters and captured values
  always_ff @(posedge clk) begin
    if (cmd.begin_run) begin
      e <= n_eff + NW'(1);
      i <= '0;
    end
    if (cmd.init_cap) begin
      rowi <= mrow;
      np   <= '0;
      ns   <= '0;
      j    <= '0;
    end
    if (cmd.init_acc) begin
      np <= np + 7'(mrow[i]);
      ns <= ns + 7'(rowi[j]);
    end
    if (cmd.init_acc || cmd.adv_j || cmd.fwd_upd || cmd.bwd_upd) begin
      j <= j + NW'(1);
    end
    if (cmd.init_wr || cmd.emit) begin
      i <= i + NW'(1);
    end
    if (cmd.take_node) begin
      cur <= q_q;
    end
    if (cmd.fwd_fin) begin
      row <= mrow;
      fin <= (cur == '0) ? 16'd0 : ef_q[15:0];
      j   <= '0;
    end
    if (cmd.end_cap) begin
      plen   <= ef_q[16] ? 16'd0 : ef_q[15:0];
      es_end <= es_q;
      ef_end <= ef_q[15:0];
      i      <= NW'(1);
    end
    if (cmd.bwd_cap) begin
      lsv <= ls_q[15:0];
      j   <= '0;
    end
    if (cmd.emit) begin
      task_id        <= i;
      earliest_start <= es_q;
      early_finish   <= ef_q;
      late_start     <= ls_q;
      late_finish    <= lf_q;
      on_critical    <= !es_q[16] && (es_q == ls_q);
      last_task      <= (i == e - NW'(1));
    end
  end

  assign project_length = plen;

endmodule

FILE: hw/rtl/critical_path_scheduler.sv
`timescale 1ns / 1ps
// channel   signals                                    handshake
// input     action node_a node_b task_time             start & !busy
// result    task_id earliest_start early_finish ...    result_valid, one cycle
// config    psel penable pwrite paddr pwdata prdata    apb write, pready tied high
//
// set duration, add edge and clear graph are taken back to back while idle.
// compute: rebuild the pending counts, then a forward pass in which each queued
// node scans its matrix row and relaxes every edge leaving it, then, if the end
// node was reached, a backward pass over each queued node, then the results;
// all steps share the single matrix read port.
// rst is synchronous; the receiver cannot stall, results are never back to back.

module critical_path_scheduler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [cpm_pkg::NODE_W-1:0]   node_a,
  input  logic [cpm_pkg::NODE_W-1:0]   node_b,
  input  logic [cpm_pkg::TIME_W-1:0]   task_time,
  output logic                         result_valid,
  output logic [cpm_pkg::NODE_W-1:0]   task_id,
  output logic signed [16:0]           earliest_start,
  output logic signed [16:0]           early_finish,
  output logic signed [16:0]           late_start,
  output logic [15:0]                  late_finish,
  output logic                         on_critical,
  output logic [15:0]                  project_length,
  output logic                         last_task,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  cpm_pkg::cmd_t    cmd;
  cpm_pkg::status_t stat;
  logic [cpm_pkg::NODE_W-1:0] task_count;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= cpm_pkg::NODE_W'(1);
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == cpm_pkg::REG_TASK_COUNT)) begin
      task_count <= pwdata[cpm_pkg::NODE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == cpm_pkg::REG_TASK_COUNT) ? 32'(task_count) : 32'd0;

  cpm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  cpm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .task_count     (task_count),
    .action         (action),
    .node_a         (node_a),
    .node_b         (node_b),
    .task_time      (task_time),
    .result_valid   (result_valid),
    .task_id        (task_id),
    .earliest_start (earliest_start),
    .early_finish   (early_finish),
    .late_start     (late_start),
    .late_finish    (late_finish),
    .on_critical    (on_critical),
    .project_length (project_length),
    .last_task      (last_task)
  );

endmodule

FILE: hw/rtl/cpm_checker.sv
`timescale 1ns / 1ps

module cpm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 action,
  input logic                       result_valid,
  input logic [cpm_pkg::NODE_W-1:0] task_id,
  input logic                       last_task
);

  // a word only follows a busy cycle
  a_word_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result word without a busy cycle before it");

  // words are never back to back
  a_word_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result words back to back");

  // block is idle while the last word is out
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_task) |-> !busy)
    else $error("still busy with last word");

  // load items never make the block busy
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action != cpm_pkg::ACT_RUN)) |=> !busy)
    else $error("load item left block busy");

  // task ids are real tasks
  a_task_id: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (task_id != '0))
    else $error("result word for start node");

endmodule

bind critical_path_scheduler cpm_checker u_cpm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .result_valid (result_valid),
  .task_id      (task_id),
  .last_task    (last_task)
);
